/* src/b4rc_pkg.sv */
// Shared types, opcodes and status codes of the four-register byte core.
package b4rc_pkg;

    typedef logic [31:0] word_t;
    typedef logic [1:0]  ridx_t;

    // Upper six bits of the in/out instruction group
    localparam logic [5:0] OP_IN  = 6'h30;
    localparam logic [5:0] OP_OUT = 6'h31;

    // Low two bits of the arithmetic nibble (1000..1011)
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;
    localparam logic [1:0] ALU_DIV = 2'd3;

    // Register indexes; MOVI loads D
    localparam ridx_t REG_A = 2'd0;
    localparam ridx_t REG_B = 2'd1;
    localparam ridx_t REG_C = 2'd2;
    localparam ridx_t REG_D = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_IO   = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    // Divider iteration count (one quotient bit per step)
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_instr;
        logic exec;
        logic div_step;
        logic div_finish;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_go;
        logic div_last;
    } stat_t;

endpackage

/* src/b4rc_ram.sv */
// Generic RAM: one write port, two registered read ports.
module b4rc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write and registered reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* src/b4rc_ctrl.sv */
// Controller state machine: sequences fetch, execute, divide and result handoff.
module b4rc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output b4rc_pkg::cmd_t  cmd,
    input  b4rc_pkg::stat_t stat
);
    import b4rc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       full_reg;
    logic       full_next;
    logic       slot_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = full_reg;
    assign slot_free = !full_reg || m_tready;

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_instr = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.div_go ? S_DIV : S_WB;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.div_finish = 1'b1;
                state_next     = S_WB;
            end
            S_WB: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output slot occupancy
    always_comb begin
        if (cmd.out_load) begin
            full_next = 1'b1;
        end else if (m_tready) begin
            full_next = 1'b0;
        end else begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            full_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            full_reg  <= full_next;
        end
    end

endmodule

/* src/b4rc_dpath.sv */
// Datapath: instruction latch, register file, ALU, iterative divider, result registers.
module b4rc_dpath (
    input  logic            aclk,
    input  logic            aresetn,
    input  b4rc_pkg::cmd_t  cmd,
    output b4rc_pkg::stat_t stat,
    input  logic [39:0]     s_tdata,
    output logic [31:0]     out_value,
    output logic            out_flag,
    output logic [1:0]      out_status
);
    import b4rc_pkg::*;

    logic [7:0]   instr_reg;
    word_t        inval_reg;
    logic [7:0]   instr_now;
    ridx_t        ra_idx;
    ridx_t        rb_idx;
    word_t        ra_raw;
    word_t        rb_raw;
    word_t        a;
    word_t        b;
    logic [3:0]   vld_reg;
    logic         rf_we;
    ridx_t        rf_wa;
    word_t        rf_wd;

    logic         is_movi;
    logic         is_io;
    logic         is_div;
    logic [1:0]   alu_op;

    word_t        div_rem_reg;
    word_t        div_quo_reg;
    word_t        div_mb_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic         div_neg_reg;
    logic [32:0]  div_shift;
    logic [32:0]  div_diff;

    logic         pend_load;
    logic         pend_flag;
    word_t        pend_value;
    logic [1:0]   pend_status;
    logic         pend_flag_reg;
    word_t        pend_value_reg;
    logic [1:0]   pend_status_reg;
    logic         out_flag_reg;
    word_t        out_value_reg;
    logic [1:0]   out_status_reg;

    // Instruction latch on accept
    always_ff @(posedge aclk) begin
        if (cmd.load_instr) begin
            instr_reg <= s_tdata[7:0];
            inval_reg <= s_tdata[39:8];
        end
    end

    // Read addresses follow the instruction being latched
    assign instr_now = cmd.load_instr ? s_tdata[7:0] : instr_reg;
    assign ra_idx    = instr_now[7] ? instr_now[3:2] : instr_now[1:0];
    assign rb_idx    = instr_now[1:0];

    b4rc_ram #(
        .WIDTH (32),
        .DEPTH (4)
    ) u_rf (
        .aclk    (aclk),
        .we      (rf_we),
        .waddr   (rf_wa),
        .wdata   (rf_wd),
        .raddr_a (ra_idx),
        .rdata_a (ra_raw),
        .raddr_b (rb_idx),
        .rdata_b (rb_raw)
    );

    // Registers never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (rf_we) begin
            vld_reg[rf_wa] <= 1'b1;
        end
    end

    assign a = vld_reg[ra_idx] ? ra_raw : '0;
    assign b = vld_reg[rb_idx] ? rb_raw : '0;

    // Decode
    assign is_movi = !instr_reg[7];
    assign is_io   = instr_reg[7] && instr_reg[6];
    assign alu_op  = instr_reg[5:4];
    assign is_div  = instr_reg[7] && !instr_reg[6] && (alu_op == ALU_DIV);

    assign stat.div_go   = is_div && (b != '0);
    assign stat.div_last = (div_cnt_reg == CNT_W'(DIV_STEPS - 1));

    // Execute: register write and pending result
    always_comb begin
        rf_we       = 1'b0;
        rf_wa       = instr_reg[1:0];
        rf_wd       = '0;
        pend_flag   = 1'b0;
        pend_value  = '0;
        pend_status = ST_OK;
        pend_load   = 1'b0;
        if (cmd.exec) begin
            pend_load = !stat.div_go;
            if (is_movi) begin
                rf_we = 1'b1;
                rf_wa = REG_D;
                rf_wd = {25'd0, instr_reg[6:0]};
            end else if (is_io) begin
                if (instr_reg[7:2] == OP_OUT) begin
                    pend_flag  = 1'b1;
                    pend_value = b;
                end else if (instr_reg[7:2] == OP_IN) begin
                    rf_we = 1'b1;
                    rf_wd = inval_reg;
                end else begin
                    pend_status = ST_BAD_IO;
                end
            end else begin
                rf_wa = instr_reg[3:2];
                case (alu_op)
                    ALU_ADD: begin
                        rf_we = 1'b1;
                        rf_wd = a + b;
                    end
                    ALU_SUB: begin
                        rf_we = 1'b1;
                        rf_wd = a - b;
                    end
                    ALU_MUL: begin
                        rf_we = 1'b1;
                        rf_wd = a * b;
                    end
                    ALU_DIV: begin
                        if (b == '0) begin
                            pend_status = ST_DIV_ZERO;
                        end
                    end
                    default: begin
                        rf_we = 1'b0;
                    end
                endcase
            end
        end else if (cmd.div_finish) begin
            pend_load = 1'b1;
            rf_we     = 1'b1;
            rf_wa     = instr_reg[3:2];
            rf_wd     = div_neg_reg ? (32'd0 - div_quo_reg) : div_quo_reg;
        end
    end

    // Restoring divider on magnitudes, one quotient bit per step
    assign div_shift = {div_rem_reg, div_quo_reg[31]};
    assign div_diff  = div_shift - {1'b0, div_mb_reg};

    always_ff @(posedge aclk) begin
        if (cmd.exec && stat.div_go) begin
            div_rem_reg <= '0;
            div_quo_reg <= a[31] ? (32'd0 - a) : a;
            div_mb_reg  <= b[31] ? (32'd0 - b) : b;
            div_neg_reg <= a[31] ^ b[31];
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            if (!div_diff[32]) begin
                div_rem_reg <= div_diff[31:0];
                div_quo_reg <= {div_quo_reg[30:0], 1'b1};
            end else begin
                div_rem_reg <= div_shift[31:0];
                div_quo_reg <= {div_quo_reg[30:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Pending result, then output register
    always_ff @(posedge aclk) begin
        if (pend_load) begin
            pend_flag_reg   <= pend_flag;
            pend_value_reg  <= pend_value;
            pend_status_reg <= pend_status;
        end
        if (cmd.out_load) begin
            out_flag_reg   <= pend_flag_reg;
            out_value_reg  <= pend_value_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    assign out_flag   = out_flag_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

/* src/byte_isa_four_register_core.sv */
// Top level of the four-register byte instruction core.
//
// Executes one 8-bit instruction per item against four 32-bit registers
// (all zero after reset): MOVI, IN, OUT, ADD, SUB, MUL and DIV. Every item
// gives exactly one result item carrying the OUT flag, the OUT value (zero
// otherwise) and a status (ok, bad in/out code, divide by zero); on an error
// the registers are left as they were. From accept the core steps through
// execute and writeback before it is ready again; a DIV with a nonzero
// divisor adds divide steps and a finish state, its restoring divider
// producing one quotient bit per cycle. Writeback waits for a free output.
// The next item is accepted while a finished result still waits on the output.
module byte_isa_four_register_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] instr_byte, [39:8] in_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] out_value
    output logic [2:0]  m_tuser    // [0] out_valid, [2:1] status
);
    import b4rc_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic        out_flag;
    logic [1:0]  out_status;

    b4rc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    b4rc_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_tdata    (s_tdata),
        .out_value  (m_tdata),
        .out_flag   (out_flag),
        .out_status (out_status)
    );

    assign m_tuser = {out_status, out_flag};

    // One item in flight: no accept right after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item still executing");

    // OUT results never carry an error status
    a_out_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ST_OK))
        else $error("OUT result with error status");

    // Non-OUT results carry a zero value
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("non-OUT result with nonzero value");

    // A result is only loaded once the previous one is taken or absent
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("pending result overwritten");

endmodule
